/* hw/rtl/rtud_pkg.sv */
// Shared types, constants and the CRC-16 fold for the RTU response deframer.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package rtud_pkg;

  localparam int MAX_FRAME_BYTES = 511;
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int EXP_W = 10;
  localparam int CMP_W = (CNT_W > EXP_W) ? CNT_W : EXP_W;
  localparam int LEN_W = 9;
  localparam int LEN_CAP = 511;

  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_LSB  = 16'h0001;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_READ_CODE       = 3'd0,
    REG_WRITE_CODE      = 3'd1,
    REG_EXCEPTION_MASK  = 3'd2,
    REG_EXCEPTION_LEN   = 3'd3,
    REG_READ_HEADER_LEN = 3'd4,
    REG_WRITE_LEN       = 3'd5
  } cfg_reg_e;

  localparam logic [BYTE_W-1:0] RST_READ_CODE       = 8'd3;
  localparam logic [BYTE_W-1:0] RST_WRITE_CODE      = 8'd16;
  localparam logic [BYTE_W-1:0] RST_EXCEPTION_MASK  = 8'd128;
  localparam logic [BYTE_W-1:0] RST_EXCEPTION_LEN   = 8'd3;
  localparam logic [BYTE_W-1:0] RST_READ_HEADER_LEN = 8'd3;
  localparam logic [BYTE_W-1:0] RST_WRITE_LEN       = 8'd6;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_NO_RESP = 2'd2
  } status_e;

  localparam logic CMD_BYTE     = 1'b0;
  localparam logic CMD_GAP      = 1'b1;
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] read_code;
    logic [BYTE_W-1:0] write_code;
    logic [BYTE_W-1:0] exception_mask;
    logic [BYTE_W-1:0] exception_len;
    logic [BYTE_W-1:0] read_header_len;
    logic [BYTE_W-1:0] write_len;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [1:0]        status;
    logic              ended_by_gap;
    logic [LEN_W-1:0]  frame_length;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic      pay_valid;
    logic      stat_valid;
    out_word_t pay_word;
    out_word_t stat_word;
  } core_res_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_LSB) != 16'h0000) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rtu_response_deframer_unit.sv */
// Top level of the RTU response deframer: config registers, input register, frame core, result queue.
// Depends on rtud_pkg, rtud_cfg_regs, rtud_frame_core and rtud_out_fifo.
//
// Input channel (in_valid/in_ready/in_data) carries one word per received
// serial byte (cmd = byte) or per line gap (cmd = gap). Output channel
// (out_valid/out_ready/out_data) carries payload words and one status word
// per frame; status words have last set. The write port (cfg_wr_en,
// cfg_index, cfg_wdata) sets the six 8-bit registers, one per cycle.
// Throughput: one input word per cycle while the queue has room. A word
// yields zero, one or two results; two only at the word that completes
// a frame by length. The results of the input register's word go together
// into the result queue, the second behind the first. The CRC-16 fold and length
// compare sit between the input register and the 4-entry result queue.
// When the receiver stalls, the queue fills; the input register then holds
// and in_ready drops once fewer than two queue entries are free.
// Reset clears the frame state, empties the queue and restores register
// defaults; the block takes words in the first cycle after reset.
`default_nettype none

module rtu_response_deframer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rtud_pkg::in_word_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output rtud_pkg::out_word_t                 out_data,
  input  wire logic                           cfg_wr_en,
  input  wire logic [rtud_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rtud_pkg::BYTE_W-1:0]    cfg_wdata
);

  rtud_pkg::cfg_t                   cfg;
  rtud_pkg::in_word_t               in_q;
  logic                             in_q_valid;
  logic                             room;
  logic                             advance;
  logic                             pop;
  rtud_pkg::core_res_t              res;
  logic [rtud_pkg::FIFO_CNT_W-1:0]  level;
  logic [rtud_pkg::CNT_W-1:0]       frame_bytes;

  rtud_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign room     = (level <= rtud_pkg::FIFO_CNT_W'(rtud_pkg::FIFO_DEPTH - 2));
  assign advance  = in_q_valid && room;
  assign in_ready = !in_q_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  rtud_frame_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (advance),
    .word        (in_q),
    .res         (res),
    .frame_bytes (frame_bytes)
  );

  assign pop = out_valid && out_ready;

  rtud_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (advance),
    .res   (res),
    .pop   (pop),
    .head  (out_data),
    .level (level)
  );

  assign out_valid = (level != '0);

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= rtud_pkg::FIFO_CNT_W'(rtud_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_gap_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.cmd == rtud_pkg::CMD_GAP |=> frame_bytes == '0)
    else $error("frame state not cleared after gap");

  a_status_on_gap: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.cmd == rtud_pkg::CMD_GAP |-> res.stat_valid && !res.pay_valid)
    else $error("gap word must yield exactly one status");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !room |=> $stable(in_q) && in_q_valid)
    else $error("input register lost a word while the queue was full");

endmodule

`default_nettype wire

/* hw/rtl/rtud_cfg_regs.sv */
// Configuration register file for the RTU response deframer.
// Depends on rtud_pkg for the register map, reset values and cfg_t.
`default_nettype none

module rtud_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [rtud_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rtud_pkg::BYTE_W-1:0]    cfg_wdata,
  output rtud_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_code       <= rtud_pkg::RST_READ_CODE;
      cfg.write_code      <= rtud_pkg::RST_WRITE_CODE;
      cfg.exception_mask  <= rtud_pkg::RST_EXCEPTION_MASK;
      cfg.exception_len   <= rtud_pkg::RST_EXCEPTION_LEN;
      cfg.read_header_len <= rtud_pkg::RST_READ_HEADER_LEN;
      cfg.write_len       <= rtud_pkg::RST_WRITE_LEN;
    end else if (cfg_wr_en) begin
      unique case (rtud_pkg::cfg_reg_e'(cfg_index))
        rtud_pkg::REG_READ_CODE:       cfg.read_code       <= cfg_wdata;
        rtud_pkg::REG_WRITE_CODE:      cfg.write_code      <= cfg_wdata;
        rtud_pkg::REG_EXCEPTION_MASK:  cfg.exception_mask  <= cfg_wdata;
        rtud_pkg::REG_EXCEPTION_LEN:   cfg.exception_len   <= cfg_wdata;
        rtud_pkg::REG_READ_HEADER_LEN: cfg.read_header_len <= cfg_wdata;
        rtud_pkg::REG_WRITE_LEN:       cfg.write_len       <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rtud_frame_core.sv */
// Frame state, CRC-16 fold, length check and result build for one word.
// Depends on rtud_pkg for types, constants and crc_fold.
`default_nettype none

module rtud_frame_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rtud_pkg::cfg_t              cfg,
  input  wire logic                        step,
  input  wire rtud_pkg::in_word_t          word,
  output rtud_pkg::core_res_t              res,
  output logic [rtud_pkg::CNT_W-1:0]       frame_bytes
);

  logic [rtud_pkg::CNT_W-1:0]  cnt;
  logic [rtud_pkg::BYTE_W-1:0] func;
  logic [rtud_pkg::BYTE_W-1:0] data;
  logic [15:0]                 crc;
  logic [rtud_pkg::BYTE_W-1:0] d0;
  logic [rtud_pkg::BYTE_W-1:0] d1;

  logic [rtud_pkg::CNT_W-1:0]  cnt_next;
  logic [rtud_pkg::BYTE_W-1:0] func_next;
  logic [rtud_pkg::BYTE_W-1:0] data_next;
  logic [15:0]                 crc_next;

  logic                        is_gap;
  logic                        known;
  logic                        done;
  logic [rtud_pkg::EXP_W-1:0]  expected;
  logic [rtud_pkg::CMP_W-1:0]  cnt_cmp;
  logic [rtud_pkg::CNT_W-1:0]  s_cnt;
  logic [15:0]                 s_crc;
  logic [15:0]                 s_rx;
  logic [1:0]                  st;

  always_comb begin
    is_gap    = (word.cmd == rtud_pkg::CMD_GAP);
    crc_next  = (cnt >= rtud_pkg::CNT_W'(2)) ? rtud_pkg::crc_fold(crc, d1) : crc;
    cnt_next  = (cnt < rtud_pkg::CNT_W'(rtud_pkg::MAX_FRAME_BYTES)) ?
                cnt + rtud_pkg::CNT_W'(1) : cnt;
    func_next = (cnt == rtud_pkg::CNT_W'(1)) ? word.rx_byte : func;
    data_next = (cnt == rtud_pkg::CNT_W'(2)) ? word.rx_byte : data;
    cnt_cmp   = rtud_pkg::CMP_W'(cnt_next);

    known    = 1'b0;
    expected = '0;
    if (cnt_next >= rtud_pkg::CNT_W'(2)) begin
      if ((func_next & cfg.exception_mask) != '0) begin
        known    = 1'b1;
        expected = rtud_pkg::EXP_W'(cfg.exception_len) + rtud_pkg::EXP_W'(2);
      end else if (func_next == cfg.read_code) begin
        if (cnt_next >= rtud_pkg::CNT_W'(3) &&
            cnt_cmp >= rtud_pkg::CMP_W'(cfg.read_header_len)) begin
          known    = 1'b1;
          expected = rtud_pkg::EXP_W'(cfg.read_header_len) +
                     rtud_pkg::EXP_W'(data_next) + rtud_pkg::EXP_W'(2);
        end
      end else if (func_next == cfg.write_code) begin
        known    = 1'b1;
        expected = rtud_pkg::EXP_W'(cfg.write_len) + rtud_pkg::EXP_W'(2);
      end
    end
    done = !is_gap && known && (cnt_cmp >= rtud_pkg::CMP_W'(expected));

    s_cnt = is_gap ? cnt : cnt_next;
    s_crc = is_gap ? crc : crc_next;
    s_rx  = is_gap ? {d0, d1} : {word.rx_byte, d0};
    if (s_cnt == '0) begin
      st = rtud_pkg::ST_NO_RESP;
    end else if (s_cnt == rtud_pkg::CNT_W'(1)) begin
      st = rtud_pkg::ST_CRC_ERR;
    end else begin
      st = (s_rx == s_crc) ? rtud_pkg::ST_OK : rtud_pkg::ST_CRC_ERR;
    end

    res.pay_valid               = !is_gap && (cnt >= rtud_pkg::CNT_W'(3));
    res.pay_word.kind           = rtud_pkg::KIND_PAYLOAD;
    res.pay_word.payload_byte   = d1;
    res.pay_word.status         = rtud_pkg::ST_OK;
    res.pay_word.ended_by_gap   = 1'b0;
    res.pay_word.frame_length   = '0;
    res.pay_word.last           = 1'b0;

    res.stat_valid              = is_gap || done;
    res.stat_word.kind          = rtud_pkg::KIND_STATUS;
    res.stat_word.payload_byte  = '0;
    res.stat_word.status        = st;
    res.stat_word.ended_by_gap  = is_gap;
    res.stat_word.frame_length  =
      (rtud_pkg::CMP_W'(s_cnt) > rtud_pkg::CMP_W'(rtud_pkg::LEN_CAP)) ?
      rtud_pkg::LEN_W'(rtud_pkg::LEN_CAP) : rtud_pkg::LEN_W'(s_cnt);
    res.stat_word.last          = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      func <= '0;
      data <= '0;
      crc  <= rtud_pkg::CRC_INIT;
      d0   <= '0;
      d1   <= '0;
    end else if (step) begin
      if (is_gap || done) begin
        cnt  <= '0;
        func <= '0;
        data <= '0;
        crc  <= rtud_pkg::CRC_INIT;
        d0   <= '0;
        d1   <= '0;
      end else begin
        cnt  <= cnt_next;
        func <= func_next;
        data <= data_next;
        crc  <= crc_next;
        d0   <= word.rx_byte;
        d1   <= d0;
      end
    end
  end

  assign frame_bytes = cnt;

endmodule

`default_nettype wire

/* hw/rtl/rtud_out_fifo.sv */
// Result queue: takes up to two result words per push, delivers one per cycle while popped.
// Depends on rtud_pkg for out_word_t, core_res_t and queue sizing.
`default_nettype none

module rtud_out_fifo (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire rtud_pkg::core_res_t            res,
  input  wire logic                           pop,
  output rtud_pkg::out_word_t                 head,
  output logic [rtud_pkg::FIFO_CNT_W-1:0]     level
);

  rtud_pkg::out_word_t              mem [rtud_pkg::FIFO_DEPTH];
  logic [rtud_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [rtud_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic [rtud_pkg::FIFO_CNT_W-1:0]  n_push;
  logic [rtud_pkg::FIFO_CNT_W-1:0]  level_next;

  always_comb begin
    n_push = '0;
    if (push) begin
      n_push = rtud_pkg::FIFO_CNT_W'(res.pay_valid) +
               rtud_pkg::FIFO_CNT_W'(res.stat_valid);
    end
    level_next = level + n_push - rtud_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (res.pay_valid) begin
        mem[wr_ptr] <= res.pay_word;
        if (res.stat_valid) begin
          mem[wr_ptr + rtud_pkg::FIFO_PTR_W'(1)] <= res.stat_word;
        end
      end else if (res.stat_valid) begin
        mem[wr_ptr] <= res.stat_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + rtud_pkg::FIFO_PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + rtud_pkg::FIFO_PTR_W'(1);
      end
      level <= level_next;
    end
  end

  assign head = mem[rd_ptr];

endmodule

`default_nettype wire
